FILE: hdl/pbba_pkg.sv
// Shared types and constants of the page block bitmap allocator.
package pbba_pkg;

    localparam int OFFSET_W = 10;
    localparam int SIZE_W   = 10;
    localparam int LIMIT_W  = 8;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic [SIZE_W-1:0]  SIZE_MIN    = 10'd8;
    localparam logic [SIZE_W-1:0]  SIZE_RESET  = 10'd8;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 8'd128;

    // Register index, taken from paddr[2].
    localparam logic REG_BLK_BYTES   = 1'b0;
    localparam logic REG_BLOCK_LIMIT = 1'b1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [1:0] {
        PS_PARTIAL = 2'd0,
        PS_FULL    = 2'd1,
        PS_EMPTY   = 2'd2
    } t_page_state;

    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_FULL       = 2'd1,
        ERR_MISALIGNED = 2'd2,
        ERR_DOUBLE     = 2'd3
    } t_err;

endpackage

FILE: hdl/pbba_if.sv
// Request and response channel interfaces of the page block bitmap allocator.
interface pbba_req_if
    import pbba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                op;
    logic [OFFSET_W-1:0] byte_offset;

    modport source (output valid, output op, output byte_offset, input ready);
    modport sink   (input valid, input op, input byte_offset, output ready);
endinterface

interface pbba_rsp_if
    import pbba_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                granted;
    logic [OFFSET_W-1:0] block_address;
    logic [1:0]          page_state;
    logic [1:0]          error;

    modport source (output valid, output granted, output block_address,
                    output page_state, output error, input ready);
    modport sink   (input valid, input granted, input block_address,
                    input page_state, input error, output ready);
endinterface

FILE: hdl/page_block_bitmap_allocator.sv
// Top level: bitmap block allocator for one page, occupancy held in a row RAM.
//
// Requests arrive on i_req (op, byte_offset) and each gives exactly one
// response on o_rsp (granted, block_address, page_state, error), in order.
// The block size and block_limit are written over the APB port (byte
// addresses 0 and 4); the user must write them only while no request is
// in flight, which the block itself does not enforce; pready is always high.
// The occupancy bitmap is kept in a RAM of ROWS rows of ROW_W bits. Every
// request first runs PAGE_BYTES by the block size through a restoring
// divider, one quotient bit at a time; a free runs a second division of
// the offset. A scan then reads every row once, sets or clears the chosen
// bit in the row it belongs to and writes it back, and gathers the page
// state on the way. One request is in flight at a time. After reset the
// block zeroes every row of the RAM with i_req.ready low. The response waits
// in an output register; a stalled receiver holds the block only once the
// next result is ready, and a new request is taken while a response waits.
module page_block_bitmap_allocator
    import pbba_pkg::*;
#(
    parameter int MAX_BLOCKS = 128,
    parameter int PAGE_BYTES = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pbba_req_if.sink           i_req,
    pbba_rsp_if.source         o_rsp,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);
    // MAX_BLOCKS must be a multiple of ROW_W.
    localparam int ROW_W  = (MAX_BLOCKS >= 32) ? 16 : 8;
    localparam int ROWS   = MAX_BLOCKS / ROW_W;
    localparam int ADDR_W = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CNT_W  = $clog2(ROWS + 1);
    localparam int ROW_SH = $clog2(ROW_W);
    localparam int POS_W  = ADDR_W + ROW_SH;
    localparam int LIM_W  = POS_W + 1;
    localparam int PB_W   = $clog2(PAGE_BYTES + 1);
    localparam int DVD_W  = (PB_W > OFFSET_W) ? PB_W : OFFSET_W;
    localparam int STEP_W = $clog2(DVD_W + 1);
    localparam int PROD_W = POS_W + SIZE_W;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_DIV_LIM,
        ST_DIV_OFF,
        ST_SCAN,
        ST_MUL,
        ST_OUT
    } t_state;

    t_state              r_state;
    logic [SIZE_W-1:0]   r_blk_bytes;
    logic [LIMIT_W-1:0]  r_block_limit;

    logic                r_op;
    logic [OFFSET_W-1:0] r_offset;
    logic [SIZE_W-1:0]   r_size;
    logic [LIM_W-1:0]    r_lim;

    logic [DVD_W-1:0]    r_dvd;
    logic [SIZE_W:0]     r_rem;
    logic [STEP_W-1:0]   r_step;

    logic [CNT_W-1:0]    r_cnt;
    logic                r_pv;
    logic [ADDR_W-1:0]   r_paddr;
    logic [POS_W-1:0]    r_idx;
    logic                r_hit_ok;
    logic                r_found;
    logic                r_granted;
    logic                r_any;
    logic                r_free_below;
    t_err                r_err;
    logic [PROD_W-1:0]   r_prod;

    logic                r_out_valid;
    logic                r_out_granted;
    logic [OFFSET_W-1:0] r_out_addr;
    t_page_state         r_out_state;
    t_err                r_out_err;

    // Divider step.
    logic [SIZE_W:0]     n_rem_sh;
    logic                n_rem_ge;
    logic [SIZE_W:0]     n_rem;
    logic [DVD_W-1:0]    n_dvd;
    logic                div_last;
    logic [DVD_W-1:0]    n_lim_c;

    // Row scan.
    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [ROW_W-1:0]    ram_wdata;
    logic                ram_re;
    logic [ROW_W-1:0]    ram_rdata;
    logic [ROW_W-1:0]    lmask;
    logic [ROW_W-1:0]    fm;
    logic [ROW_SH-1:0]   first_j;
    logic                alloc_take;
    logic                free_hit;
    logic                free_bit;
    logic [ROW_W-1:0]    n_row;

    logic                cfg_wr;
    logic                req_acc;
    logic [SIZE_W-1:0]   eff_size;

    assign cfg_wr   = psel && penable && pwrite;
    assign pready   = 1'b1;
    assign req_acc  = i_req.valid && i_req.ready;
    assign eff_size = (r_blk_bytes < SIZE_MIN) ? SIZE_MIN : r_blk_bytes;

    always_comb begin
        case (paddr[2])
            REG_BLK_BYTES:   prdata = {{(PDATA_W-SIZE_W){1'b0}}, r_blk_bytes};
            REG_BLOCK_LIMIT: prdata = {{(PDATA_W-LIMIT_W){1'b0}}, r_block_limit};
            default:         prdata = '0;
        endcase
    end

    assign i_req.ready         = (r_state == ST_IDLE);
    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.granted       = r_out_granted;
    assign o_rsp.block_address = r_out_addr;
    assign o_rsp.page_state    = r_out_state;
    assign o_rsp.error         = r_out_err;

    // Restoring division, one quotient bit per cycle.
    assign n_rem_sh = {r_rem[SIZE_W-1:0], r_dvd[DVD_W-1]};
    assign n_rem_ge = (n_rem_sh >= {1'b0, r_size});
    assign n_rem    = n_rem_ge ? (n_rem_sh - {1'b0, r_size}) : n_rem_sh;
    assign n_dvd    = {r_dvd[DVD_W-2:0], n_rem_ge};
    assign div_last = (r_step == STEP_W'(DVD_W - 1));

    always_comb begin
        n_lim_c = {{(DVD_W-LIMIT_W){1'b0}}, r_block_limit};
        if (n_lim_c > DVD_W'(MAX_BLOCKS)) begin
            n_lim_c = DVD_W'(MAX_BLOCKS);
        end
        if (n_lim_c > n_dvd) begin
            n_lim_c = n_dvd;
        end
    end

    // Row processing on the data read in the previous cycle.
    always_comb begin
        for (int j = 0; j < ROW_W; j++) begin
            lmask[j] = ({1'b0, r_paddr, ROW_SH'(j)} < r_lim);
        end
        fm      = ~ram_rdata & lmask;
        first_j = '0;
        for (int j = ROW_W - 1; j >= 0; j--) begin
            if (fm[j]) begin
                first_j = ROW_SH'(j);
            end
        end
        alloc_take = (r_op == OP_ALLOC) && !r_found && (fm != '0);
        free_hit   = (r_op == OP_FREE) && r_hit_ok
                     && (r_idx[POS_W-1:ROW_SH] == r_paddr);
        free_bit   = ram_rdata[r_idx[ROW_SH-1:0]];
        n_row      = ram_rdata;
        if (alloc_take) begin
            n_row[first_j] = 1'b1;
        end
        if (free_hit && free_bit) begin
            n_row[r_idx[ROW_SH-1:0]] = 1'b0;
        end
    end

    always_comb begin
        ram_re    = (r_state == ST_SCAN) && (r_cnt < CNT_W'(ROWS));
        ram_we    = 1'b0;
        ram_waddr = r_paddr;
        ram_wdata = n_row;
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_cnt[ADDR_W-1:0];
            ram_wdata = '0;
        end else if (r_state == ST_SCAN && r_pv) begin
            ram_we = alloc_take || (free_hit && free_bit);
        end
    end

    pbba_ram #(
        .WIDTH (ROW_W),
        .DEPTH (ROWS)
    ) u_occ_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (r_cnt[ADDR_W-1:0]),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_CLEAR;
            r_cnt         <= '0;
            r_pv          <= 1'b0;
            r_out_valid   <= 1'b0;
            r_blk_bytes   <= SIZE_RESET;
            r_block_limit <= LIMIT_RESET;
        end else begin
            if (cfg_wr) begin
                case (paddr[2])
                    REG_BLK_BYTES:   r_blk_bytes   <= pwdata[SIZE_W-1:0];
                    REG_BLOCK_LIMIT: r_block_limit <= pwdata[LIMIT_W-1:0];
                    default:         r_blk_bytes   <= r_blk_bytes;
                endcase
            end
            // The output state reloads the register itself.
            if (o_rsp.ready && r_state != ST_OUT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                ST_CLEAR: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == CNT_W'(ROWS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (req_acc) begin
                        r_op         <= i_req.op;
                        r_offset     <= i_req.byte_offset;
                        r_size       <= eff_size;
                        r_dvd        <= DVD_W'(PAGE_BYTES);
                        r_rem        <= '0;
                        r_step       <= '0;
                        r_err        <= ERR_NONE;
                        r_hit_ok     <= 1'b0;
                        r_found      <= 1'b0;
                        r_granted    <= 1'b0;
                        r_any        <= 1'b0;
                        r_free_below <= 1'b0;
                        r_state      <= ST_DIV_LIM;
                    end
                end
                ST_DIV_LIM: begin
                    if (div_last) begin
                        r_lim <= n_lim_c[LIM_W-1:0];
                        r_cnt <= '0;
                        r_pv  <= 1'b0;
                        if (r_op == OP_FREE) begin
                            r_dvd   <= {{(DVD_W-OFFSET_W){1'b0}}, r_offset};
                            r_rem   <= '0;
                            r_step  <= '0;
                            r_state <= ST_DIV_OFF;
                        end else begin
                            r_state <= ST_SCAN;
                        end
                    end else begin
                        r_dvd  <= n_dvd;
                        r_rem  <= n_rem;
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DIV_OFF: begin
                    r_dvd  <= n_dvd;
                    r_rem  <= n_rem;
                    r_step <= r_step + 1'b1;
                    if (div_last) begin
                        if (n_rem != '0) begin
                            r_err <= ERR_MISALIGNED;
                        end else if (n_dvd >= DVD_W'(MAX_BLOCKS)) begin
                            // beyond the bitmap: reads as a free block
                            r_err <= ERR_DOUBLE;
                        end else begin
                            r_idx    <= n_dvd[POS_W-1:0];
                            r_hit_ok <= 1'b1;
                        end
                        r_state <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_pv    <= ram_re;
                    r_paddr <= r_cnt[ADDR_W-1:0];
                    if (ram_re) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_pv) begin
                        r_any        <= r_any || (n_row != '0);
                        r_free_below <= r_free_below || ((~n_row & lmask) != '0);
                        if (alloc_take) begin
                            r_found   <= 1'b1;
                            r_granted <= 1'b1;
                            r_idx     <= {r_paddr, first_j};
                        end
                        if (free_hit) begin
                            if (free_bit) begin
                                r_granted <= 1'b1;
                            end else begin
                                r_err <= ERR_DOUBLE;
                            end
                        end
                        if (!ram_re) begin
                            r_state <= ST_MUL;
                        end
                    end
                end
                ST_MUL: begin
                    r_prod <= {{SIZE_W{1'b0}}, r_idx} * {{POS_W{1'b0}}, r_size};
                    if (r_op == OP_ALLOC && !r_found) begin
                        r_err <= ERR_FULL;
                    end
                    r_state <= ST_OUT;
                end
                ST_OUT: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out_valid   <= 1'b1;
                        r_out_granted <= r_granted;
                        r_out_addr    <= (r_op == OP_ALLOC && r_found)
                                         ? r_prod[OFFSET_W-1:0] : '0;
                        r_out_state   <= !r_any ? PS_EMPTY
                                         : (r_free_below ? PS_PARTIAL : PS_FULL);
                        r_out_err     <= r_err;
                        r_state       <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    a_grant_no_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.granted) |-> (o_rsp.error == ERR_NONE))
        else $error("granted response carries an error code");

    a_addr_zero_on_reject: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && !o_rsp.granted) |-> (o_rsp.block_address == '0))
        else $error("rejected response carries a block address");

    a_full_not_partial: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.error == ERR_FULL) |-> (o_rsp.page_state != PS_PARTIAL))
        else $error("page full error with a partial page");

    a_ram_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_we && ram_re) |-> (ram_waddr != r_cnt[ADDR_W-1:0]))
        else $error("row written and read in the same cycle");

    a_accept_starts_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_acc |=> (r_state == ST_DIV_LIM))
        else $error("accepted request did not start the divider");
endmodule

FILE: hdl/pbba_ram.sv
// Generic simple dual-port RAM with registered read.
module pbba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: verif/tb.sv
// Self-checking testbench for the page block bitmap allocator: request traffic, register access.
module tb;
    import pbba_pkg::*;

    localparam int MAX_BLK  = 128;
    localparam int PAGE_SZ  = 1024;
    localparam int SETTLE   = 40;
    localparam int PHASES   = 12;
    localparam int PHASE_N  = 96;

    typedef struct packed {
        logic                granted;
        logic [OFFSET_W-1:0] block_address;
        t_page_state         page_state;
        t_err                error;
    } t_alloc_rsp;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    pbba_req_if req_ch ();
    pbba_rsp_if rsp_ch ();

    page_block_bitmap_allocator #(
        .MAX_BLOCKS(MAX_BLK),
        .PAGE_BYTES(PAGE_SZ)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch),
        .psel   (psel),
        .penable(penable),
        .pwrite (pwrite),
        .paddr  (paddr),
        .pwdata (pwdata),
        .prdata (prdata),
        .pready (pready)
    );

    // Shadow of the block: occupancy map and register contents.
    logic [MAX_BLK-1:0] occ_map;
    logic [SIZE_W-1:0]  blk_size_reg;
    logic [LIMIT_W-1:0] blk_limit_reg;

    t_alloc_rsp  pending_rsp[$];
    t_alloc_rsp  head_rsp;
    int unsigned mismatches;
    int unsigned burst_left;

    function automatic int unsigned eff_block_bytes();
        return (blk_size_reg < SIZE_MIN) ? int'(SIZE_MIN) : int'(blk_size_reg);
    endfunction

    function automatic int unsigned usable_blocks();
        int unsigned lim;
        int unsigned fit;
        lim = blk_limit_reg;
        fit = PAGE_SZ / eff_block_bytes();
        if (lim > MAX_BLK) lim = MAX_BLK;
        if (lim > fit) lim = fit;
        return lim;
    endfunction

    function automatic int unsigned lowest_free_block();
        int unsigned lim;
        lim = usable_blocks();
        for (int unsigned i = 0; i < lim; i++) begin
            if (!occ_map[i]) return i;
        end
        return lim;
    endfunction

    function automatic t_page_state page_state_now();
        if (occ_map == '0) return PS_EMPTY;
        if (lowest_free_block() >= usable_blocks()) return PS_FULL;
        return PS_PARTIAL;
    endfunction

    // Update the shadow map for one request and return the response it must give.
    function automatic t_alloc_rsp serve_request(logic op, logic [OFFSET_W-1:0] off);
        t_alloc_rsp  r;
        int unsigned sz;
        int unsigned idx;
        sz = eff_block_bytes();
        r.granted       = 1'b0;
        r.block_address = '0;
        r.error         = ERR_NONE;
        if (op == OP_ALLOC) begin
            idx = lowest_free_block();
            if (idx < usable_blocks()) begin
                occ_map[idx]    = 1'b1;
                r.granted       = 1'b1;
                r.block_address = OFFSET_W'(idx * sz);
            end else begin
                r.error = ERR_FULL;
            end
        end else if (int'(off) % sz != 0) begin
            r.error = ERR_MISALIGNED;
        end else begin
            idx = int'(off) / sz;
            // Offsets past the bitmap read as free blocks.
            if (idx >= MAX_BLK || !occ_map[idx]) begin
                r.error = ERR_DOUBLE;
            end else begin
                occ_map[idx] = 1'b0;
                r.granted    = 1'b1;
            end
        end
        r.page_state = page_state_now();
        return r;
    endfunction

    // Offset of a random block that is in use and addressable, if any.
    function automatic bit used_block_offset(output logic [OFFSET_W-1:0] off);
        int unsigned start;
        int unsigned i;
        int unsigned sz;
        start = $urandom_range(0, MAX_BLK - 1);
        sz    = eff_block_bytes();
        off   = '0;
        for (int unsigned k = 0; k < MAX_BLK; k++) begin
            i = (start + k) % MAX_BLK;
            if (occ_map[i] && i * sz < PAGE_SZ) begin
                off = OFFSET_W'(i * sz);
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Response side: stall in random stretches, with calm periods in between.
    initial begin
        int unsigned stall_left;
        int unsigned calm_left;
        stall_left   = 0;
        calm_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (stall_left > 0) begin
                rsp_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                rsp_ch.ready <= 1'b1;
                if (calm_left > 0) begin
                    calm_left--;
                end else if ($urandom_range(0, 7) == 0) begin
                    stall_left = $urandom_range(1, 40);
                    if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(50, 400);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (pending_rsp.size() == 0) begin
                $error("response transfer with no request outstanding");
                mismatches++;
            end else begin
                head_rsp = pending_rsp.pop_front();
                if (rsp_ch.granted !== head_rsp.granted) begin
                    $error("granted: expected %0d, got %0d", head_rsp.granted, rsp_ch.granted);
                    mismatches++;
                end
                if (rsp_ch.block_address !== head_rsp.block_address) begin
                    $error("block_address: expected %0d, got %0d",
                           head_rsp.block_address, rsp_ch.block_address);
                    mismatches++;
                end
                if (rsp_ch.page_state !== head_rsp.page_state) begin
                    $error("page_state: expected %0d, got %0d",
                           head_rsp.page_state, rsp_ch.page_state);
                    mismatches++;
                end
                if (rsp_ch.error !== head_rsp.error) begin
                    $error("error: expected %0d, got %0d", head_rsp.error, rsp_ch.error);
                    mismatches++;
                end
            end
        end
    end

    // Send one request; the sender runs in bursts separated by random gaps.
    task automatic send_request(logic op, logic [OFFSET_W-1:0] off);
        int unsigned gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60)
                                                      : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge i_clk);
                req_ch.valid       <= 1'b0;
                req_ch.op          <= 1'($urandom);
                req_ch.byte_offset <= OFFSET_W'($urandom);
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        @(negedge i_clk);
        req_ch.valid       <= 1'b1;
        req_ch.op          <= op;
        req_ch.byte_offset <= off;
        do @(posedge i_clk); while (!req_ch.ready);
        pending_rsp.push_back(serve_request(op, off));
        burst_left--;
    endtask

    // Drop valid and hold until every response has come back.
    task automatic hold_until_drained();
        @(negedge i_clk);
        req_ch.valid <= 1'b0;
        burst_left = 0;
        while (pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(logic reg_idx, logic [PDATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (reg_idx == REG_BLK_BYTES) blk_size_reg = value[SIZE_W-1:0];
        else blk_limit_reg = value[LIMIT_W-1:0];
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic check_reg(logic reg_idx);
        logic [PDATA_W-1:0] data;
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {reg_idx, 2'b00};
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        data = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (reg_idx == REG_BLK_BYTES && data[SIZE_W-1:0] !== blk_size_reg) begin
            $error("blk_bytes: expected %0d, got %0d", blk_size_reg, data[SIZE_W-1:0]);
            mismatches++;
        end
        if (reg_idx == REG_BLOCK_LIMIT && data[LIMIT_W-1:0] !== blk_limit_reg) begin
            $error("block_limit: expected %0d, got %0d", blk_limit_reg, data[LIMIT_W-1:0]);
            mismatches++;
        end
    endtask

    // Reprogram the page once the block is idle; upper data bits carry noise.
    task automatic set_page_config(logic [SIZE_W-1:0] size, logic [LIMIT_W-1:0] limit);
        logic [PDATA_W-1:0] data;
        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        data              = $urandom;
        data[SIZE_W-1:0]  = size;
        write_reg(REG_BLK_BYTES, data);
        data              = $urandom;
        data[LIMIT_W-1:0] = limit;
        write_reg(REG_BLOCK_LIMIT, data);
        check_reg(REG_BLK_BYTES);
        check_reg(REG_BLOCK_LIMIT);
    endtask

    task automatic test_reset_values();
        // Allow for the bitmap clearing pass.
        repeat (MAX_BLK + 16) @(posedge i_clk);
        check_reg(REG_BLK_BYTES);
        check_reg(REG_BLOCK_LIMIT);
    endtask

    task automatic test_directed_cases();
        // Three usable blocks: fill, overflow, misaligned, double and out-of-range frees.
        set_page_config(10'd8, 8'd3);
        repeat (4) send_request(OP_ALLOC, 10'h3FF);
        send_request(OP_FREE, 10'd4);
        send_request(OP_FREE, 10'd8);
        send_request(OP_FREE, 10'd8);
        send_request(OP_FREE, 10'd1016);
        send_request(OP_FREE, 10'd1023);
        // Limit of zero, on a used page and then on an empty one.
        set_page_config(10'd8, 8'd0);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_FREE, 10'd0);
        send_request(OP_FREE, 10'd16);
        send_request(OP_ALLOC, 10'd0);
        // Oversized block: one block fits, a free past it reads as free.
        set_page_config(10'd1023, 8'd255);
        send_request(OP_ALLOC, 10'h155);
        send_request(OP_FREE, 10'd1023);
        send_request(OP_FREE, 10'd0);
        // Block size of zero acts as eight; then a size that is not a power of two.
        set_page_config(10'd0, 8'd128);
        send_request(OP_ALLOC, 10'h2AA);
        set_page_config(10'd12, 8'd128);
        send_request(OP_ALLOC, 10'd0);
        send_request(OP_ALLOC, 10'd0);
        // Free above the limit still clears a used bit.
        set_page_config(10'd12, 8'd1);
        send_request(OP_FREE, 10'd24);
        send_request(OP_FREE, 10'd12);
    endtask

    task automatic test_random_traffic();
        logic [SIZE_W-1:0]   size;
        logic [LIMIT_W-1:0]  limit;
        logic [OFFSET_W-1:0] off;
        int unsigned         alloc_pct;
        int unsigned         pick;
        int unsigned         idx;
        for (int p = 0; p < PHASES; p++) begin
            alloc_pct = $urandom_range(35, 75);
            case (p)
                0: begin size = 10'd8;    limit = 8'd128; alloc_pct = 85; end
                1: begin size = 10'd16;   limit = 8'd255; end
                2: begin size = 10'd512;  limit = 8'd128; end
                3: begin size = 10'd1023; limit = 8'd40;  end
                4: begin size = 10'd0;    limit = 8'd128; end
                5: begin size = 10'd5;    limit = 8'd64;  end
                6: begin size = 10'd24;   limit = 8'd0;   end
                7: begin size = 10'd40;   limit = 8'd1;   end
                8: begin
                    size  = SIZE_W'(8 * $urandom_range(1, 64));
                    limit = LIMIT_W'($urandom_range(1, 128));
                end
                9: begin size = SIZE_W'($urandom); limit = LIMIT_W'($urandom); end
                10: begin size = 10'd8;   limit = 8'd128; alloc_pct = 20; end
                default: begin size = 10'd64; limit = 8'd16; end
            endcase
            set_page_config(size, limit);
            for (int n = 0; n < PHASE_N; n++) begin
                if (p == 3 && n == PHASE_N / 2) hold_until_drained();
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct) begin
                    send_request(OP_ALLOC, OFFSET_W'($urandom));
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6 && used_block_offset(off)) begin
                        send_request(OP_FREE, off);
                    end else if (pick < 8) begin
                        idx = $urandom_range(0, PAGE_SZ / eff_block_bytes());
                        if (idx * eff_block_bytes() < PAGE_SZ)
                            send_request(OP_FREE, OFFSET_W'(idx * eff_block_bytes()));
                        else
                            send_request(OP_FREE, OFFSET_W'($urandom));
                    end else begin
                        send_request(OP_FREE, OFFSET_W'($urandom));
                    end
                end
            end
        end
    endtask

    initial begin
        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.op          = OP_ALLOC;
        req_ch.byte_offset = '0;
        occ_map            = '0;
        blk_size_reg       = SIZE_RESET;
        blk_limit_reg      = LIMIT_RESET;
        mismatches         = 0;
        burst_left         = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_directed_cases();
        test_random_traffic();

        hold_until_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

FILE: files.f
hdl/pbba_pkg.sv
hdl/pbba_if.sv
hdl/pbba_ram.sv
hdl/page_block_bitmap_allocator.sv
verif/tb.sv
